// ----- rtl/montgomery_curve_order_check_unit_assert.svh -----
// assertion macros for the curve order check unit
`ifndef MONTGOMERY_CURVE_ORDER_CHECK_UNIT_ASSERT_SVH
`define MONTGOMERY_CURVE_ORDER_CHECK_UNIT_ASSERT_SVH

// implication checked on every clock, muted in reset
`define MCOC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted in reset
`define MCOC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcoc_pkg
// types and constants shared by the curve order check unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mcoc_pkg;

   localparam int unsigned FIELD_W = 64;
   localparam int unsigned CSR_W   = 64;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOD_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DBL_CNT  = 2'd2;

   localparam logic [1:0] ST_PASS     = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_EARLY_Z  = 2'd2;
   localparam logic [1:0] ST_FINAL_Z  = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0] start_x_high;
      logic [FIELD_W-1:0] start_x_low;
      logic [FIELD_W-1:0] curve_a_high;
      logic [FIELD_W-1:0] curve_a_low;
   } req_payload_type;

   typedef struct packed {
      logic       passed;
      logic [1:0] status;
   } rsp_payload_type;

   // shared modular multiplier handshake
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage
`default_nettype wire

// ----- rtl/mcoc_mul.sv -----
// ----------------------------------------------------------------------------
// mcoc_mul
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mcoc_mul #(
   parameter int unsigned WIDTH = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mcoc_pkg::mul_ctl_type ctl,
   output mcoc_pkg::mul_sts_type   sts,
   input  wire logic [WIDTH-1:0]   op_a,
   input  wire logic [WIDTH-1:0]   op_b,
   input  wire logic [WIDTH-1:0]   modulus,
   output logic      [WIDTH-1:0]   product
);
   import mcoc_pkg::*;

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   dbl_sum;
   logic [WIDTH-1:0] dbl_red;
   logic [WIDTH:0]   add_sum;
   logic [WIDTH-1:0] add_red;

   // acc = 2*acc mod p, then + a mod p when the bit is set
   always_comb begin
      dbl_sum = {acc_ff, 1'b0};
      if (dbl_sum >= {1'b0, modulus}) begin
         dbl_red = dbl_sum[WIDTH-1:0] - modulus;
      end else begin
         dbl_red = dbl_sum[WIDTH-1:0];
      end
      add_sum = {1'b0, dbl_red} + {1'b0, mcand_ff};
      if (add_sum >= {1'b0, modulus}) begin
         add_red = add_sum[WIDTH-1:0] - modulus;
      end else begin
         add_red = add_sum[WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         acc_in    = '0;
         mcand_in  = op_a;
         mplier_in = op_b;
         cnt_in    = CNT_W'(WIDTH);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = mplier_ff[WIDTH-1] ? add_red : dbl_red;
         mplier_in = {mplier_ff[WIDTH-2:0], 1'b0};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = acc_ff;

`include "montgomery_curve_order_check_unit_assert.svh"
   `MCOC_ASSERT_NXT(a_mul_done_ends, done_ff, !busy_ff, "multiplier busy after done")
   `MCOC_ASSERT_IMP(a_mul_cnt_live, busy_ff, cnt_ff != '0, "multiplier count ran out")
   `MCOC_ASSERT_IMP(a_mul_no_restart, ctl.start, !busy_ff, "multiplier restarted while busy")

endmodule
`default_nettype wire

// ----- rtl/montgomery_curve_order_check_unit.sv -----
// ----------------------------------------------------------------------------
// montgomery_curve_order_check_unit
// x-only repeated doubling on a montgomery curve, checks the point order
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// req     | in  | curve coefficient a, start x (128 bits each)
// rsp     | out | passed, status
// csr     | in  | modulus low/high, doubling count
//
// each product runs on the single bit-serial multiplier (one bit a cycle)
// and is launched from a sequencer state; an item needs up to two products
// for reduction plus six products per doubling, one item at a time; the
// verdict moves into an output register when that register is free, and the
// next request beat is taken while that result waits
// reset is synchronous and clears the sequencer and valid flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module montgomery_curve_order_check_unit #(
   parameter int unsigned WIDTH = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire mcoc_pkg::req_payload_type       req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output mcoc_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                            csr_write,
   input  wire logic [mcoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mcoc_pkg::CSR_W-1:0]      csr_data
);
   import mcoc_pkg::*;

   // one-hot sequencer; each mul step launches one product and waits
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RED_A  = 13'b0000000000010,  // unused; the a*1 mod p product that reduces a is launched from S_IDLE
      S_CHK_A  = 13'b0000000000100,
      S_RED_X  = 13'b0000000001000,
      S_X2     = 13'b0000000010000,
      S_Z2     = 13'b0000000100000,
      S_XZ     = 13'b0000001000000,
      S_AXZ    = 13'b0000010000000,
      S_DD     = 13'b0000100000000,
      S_FI     = 13'b0001000000000,
      S_TEST   = 13'b0010000000000,
      S_WAIT   = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   state_type        ret_ff, ret_in;   // state after the multiplier finishes

   logic [FIELD_W-1:0] mod_lo_ff, mod_hi_ff;
   logic [7:0]         cnt_cfg_ff;
   logic [WIDTH-1:0]   p_w;

   logic [WIDTH-1:0] a_ff, a_in, x_ff, x_in, z_ff, z_in;
   logic [WIDTH-1:0] x2_ff, x2_in, z2_ff, z2_in, xz_ff, xz_in;
   logic [WIDTH-1:0] raw_x_ff, raw_x_in;
   logic [7:0]       it_ff, it_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   rsp_payload_type  verdict_ff, verdict_in;  // verdict waiting for the output register

   mul_ctl_type      mctl;
   mul_sts_type      msts;
   logic [WIDTH-1:0] mop_a, mop_b, mprod;

   logic [2*FIELD_W-1:0] mod_full;
   assign mod_full = {mod_hi_ff, mod_lo_ff};
   assign p_w      = mod_full[WIDTH-1:0];

   logic [2*FIELD_W-1:0] a_full, x_full;
   assign a_full = {req_payload.curve_a_high, req_payload.curve_a_low};
   assign x_full = {req_payload.start_x_high, req_payload.start_x_low};

   // modular helpers on values below p, full carry kept
   function automatic logic [WIDTH-1:0] f_add(input logic [WIDTH-1:0] l,
         input logic [WIDTH-1:0] r, input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, l} + {1'b0, r};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   function automatic logic [WIDTH-1:0] f_sub(input logic [WIDTH-1:0] l,
         input logic [WIDTH-1:0] r, input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] d;
      d = l - r;
      if (l < r) begin
         d = d + m;
      end
      return d;
   endfunction

   logic [WIDTH-1:0] one_w, two_w, three_w, pm2_w;
   assign one_w   = WIDTH'(1);
   assign two_w   = WIDTH'(2);
   assign three_w = WIDTH'(3);
   assign pm2_w   = p_w - two_w;

   logic accept_req;
   assign accept_req = req_valid && !req_stall;
   // a waiting result does not hold off the input, S_OUT waits for it instead
   assign req_stall  = !(state_ff == S_IDLE);

   logic last_it;
   assign last_it = (it_ff == cnt_cfg_ff);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      a_in = a_ff;  x_in = x_ff;  z_in = z_ff;
      x2_in = x2_ff; z2_in = z2_ff; xz_in = xz_ff;
      raw_x_in     = raw_x_ff;
      it_in        = it_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      verdict_in   = verdict_ff;
      mctl.start   = 1'b0;
      mop_a        = '0;
      mop_b        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_req) begin
               raw_x_in = x_full[WIDTH-1:0];
               a_in     = a_full[WIDTH-1:0];
               if (p_w < three_w) begin
                  verdict_in = '{passed: 1'b0, status: ST_SINGULAR};
                  state_in   = S_OUT;
               end else begin
                  mctl.start = 1'b1;
                  mop_a      = one_w;
                  mop_b      = a_full[WIDTH-1:0];
                  ret_in     = S_CHK_A;
                  state_in   = S_WAIT;
               end
            end
         end
         S_RED_A: begin
            state_in = S_CHK_A;
         end
         S_CHK_A: begin
            a_in = mprod;
            if (mprod == two_w || mprod == pm2_w) begin
               verdict_in = '{passed: 1'b0, status: ST_SINGULAR};
               state_in   = S_OUT;
            end else begin
               mctl.start = 1'b1;
               mop_a      = one_w;
               mop_b      = raw_x_ff;
               ret_in     = S_RED_X;
               state_in   = S_WAIT;
            end
         end
         S_RED_X: begin
            x_in  = mprod;
            z_in  = one_w;
            it_in = 8'd1;
            if (cnt_cfg_ff == 8'd0) begin
               verdict_in = '{passed: 1'b1, status: ST_PASS};
               state_in   = S_OUT;
            end else begin
               mctl.start = 1'b1;
               mop_a      = mprod;
               mop_b      = mprod;
               ret_in     = S_X2;
               state_in   = S_WAIT;
            end
         end
         S_X2: begin
            x2_in      = mprod;
            mctl.start = 1'b1;
            mop_a      = z_ff;
            mop_b      = z_ff;
            ret_in     = S_Z2;
            state_in   = S_WAIT;
         end
         S_Z2: begin
            z2_in      = mprod;
            mctl.start = 1'b1;
            mop_a      = x_ff;
            mop_b      = z_ff;
            ret_in     = S_XZ;
            state_in   = S_WAIT;
         end
         S_XZ: begin
            xz_in      = mprod;
            mctl.start = 1'b1;
            mop_a      = a_ff;
            mop_b      = mprod;
            ret_in     = S_AXZ;
            state_in   = S_WAIT;
         end
         S_AXZ: begin
            // keep inner sum in z2, 4xz in xz, difference in x2
            z2_in      = f_add(f_add(x2_ff, mprod, p_w), z2_ff, p_w);
            xz_in      = f_add(f_add(xz_ff, xz_ff, p_w),
                               f_add(xz_ff, xz_ff, p_w), p_w);
            x2_in      = f_sub(x2_ff, z2_ff, p_w);
            mctl.start = 1'b1;
            mop_a      = f_sub(x2_ff, z2_ff, p_w);
            mop_b      = f_sub(x2_ff, z2_ff, p_w);
            ret_in     = S_DD;
            state_in   = S_WAIT;
         end
         S_DD: begin
            x_in       = mprod;
            mctl.start = 1'b1;
            mop_a      = xz_ff;
            mop_b      = z2_ff;
            ret_in     = S_FI;
            state_in   = S_WAIT;
         end
         S_FI: begin
            z_in     = mprod;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (!last_it && z_ff == '0) begin
               verdict_in = '{passed: 1'b0, status: ST_EARLY_Z};
               state_in   = S_OUT;
            end else if (last_it) begin
               if (z_ff != '0) begin
                  verdict_in = '{passed: 1'b0, status: ST_FINAL_Z};
               end else begin
                  verdict_in = '{passed: 1'b1, status: ST_PASS};
               end
               state_in = S_OUT;
            end else begin
               it_in      = it_ff + 8'd1;
               mctl.start = 1'b1;
               mop_a      = x_ff;
               mop_b      = x_ff;
               ret_in     = S_X2;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (msts.done) begin
               state_in = ret_ff;
            end
         end
         S_OUT: begin
            // result register is free: the old beat left or none was held
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = verdict_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;  x_ff <= x_in;  z_ff <= z_in;
      x2_ff <= x2_in; z2_ff <= z2_in; xz_ff <= xz_in;
      raw_x_ff   <= raw_x_in;
      rsp_ff     <= rsp_in;
      verdict_ff <= verdict_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         it_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         mod_lo_ff    <= FIELD_W'(5);
         mod_hi_ff    <= '0;
         cnt_cfg_ff   <= 8'd1;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         it_ff        <= it_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MOD_LOW:  mod_lo_ff  <= csr_data;
               CSR_MOD_HIGH: mod_hi_ff  <= csr_data;
               CSR_DBL_CNT:  cnt_cfg_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   mcoc_mul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .sts     (msts),
      .op_a    (mop_a),
      .op_b    (mop_b),
      .modulus (p_w),
      .product (mprod)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "montgomery_curve_order_check_unit_assert.svh"
   `MCOC_ASSERT_IMP(a_wait_busy, state_ff == S_WAIT && !msts.done, msts.busy,
      "waiting with idle multiplier")
   `MCOC_ASSERT_IMP(a_pass_code, rsp_valid_ff,
      rsp_ff.passed == (rsp_ff.status == ST_PASS), "passed and status disagree")
   `MCOC_ASSERT_NXT(a_accept_leaves_idle, accept_req, state_ff != S_IDLE,
      "request taken but sequencer idle")

endmodule
`default_nettype wire
